// ===== rtl/tsi_pkg.sv =====
package tsi_pkg;

   localparam int STACK_DEPTH_DEF = 64;
   localparam int SINE_BITS_DEF   = 10;

   localparam int SYM_W       = 8;
   localparam int COORD_W     = 24;
   localparam int ANGLE_W     = 16;
   localparam int STEP_W      = 16;
   localparam int TRIG_W      = 16;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam real PI_VALUE = 3.14159265358979323846;

   localparam logic [ANGLE_W-1:0] TURN_STEP_RESET     = 16'd3641;
   localparam logic [STEP_W-1:0]  STEP_LENGTH_RESET   = 16'd512;
   localparam logic [COORD_W-1:0] START_X_RESET       = 24'd0;
   localparam logic [COORD_W-1:0] START_Y_RESET       = 24'd0;
   localparam logic [ANGLE_W-1:0] START_HEADING_RESET = 16'd16384;

   localparam logic [SYM_W-1:0] SYM_FORWARD = 8'h46;  // 'F'
   localparam logic [SYM_W-1:0] SYM_PUSH    = 8'h5B;  // '['
   localparam logic [SYM_W-1:0] SYM_POP     = 8'h5D;  // ']'
   localparam logic [SYM_W-1:0] SYM_LEFT    = 8'h2B;  // '+'
   localparam logic [SYM_W-1:0] SYM_RIGHT   = 8'h2D;  // '-'

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TURN_STEP     = 3'd0,
      CSR_STEP_LENGTH   = 3'd1,
      CSR_START_X       = 3'd2,
      CSR_START_Y       = 3'd3,
      CSR_START_HEADING = 3'd4
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_SEGMENT   = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      OP_IDLE      = 3'd0,
      OP_FORWARD   = 3'd1,
      OP_PUSH      = 3'd2,
      OP_POP       = 3'd3,
      OP_LEFT      = 3'd4,
      OP_RIGHT     = 3'd5,
      OP_OVERFLOW  = 3'd6,
      OP_UNDERFLOW = 3'd7
   } op_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [ANGLE_W-1:0] h;
   } turtle_type;

endpackage

// ===== rtl/tsi_ifs.sv =====
interface tsi_req_if import tsi_pkg::*; ;
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;
   logic             word_start;

   modport source (output valid, symbol, word_start, input ready);
   modport sink   (input valid, symbol, word_start, output ready);
endinterface

interface tsi_rsp_if import tsi_pkg::*; ;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] seg_x0;
   logic signed [COORD_W-1:0] seg_y0;
   logic signed [COORD_W-1:0] seg_x1;
   logic signed [COORD_W-1:0] seg_y1;
   logic [STATUS_W-1:0]       status;

   modport source (output valid, seg_x0, seg_y0, seg_x1, seg_y1, status, input ready);
   modport sink   (input valid, seg_x0, seg_y0, seg_x1, seg_y1, status, output ready);
endinterface

interface tsi_csr_if import tsi_pkg::*; ;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/tsi_stack_mem.sv =====
module tsi_stack_mem import tsi_pkg::*; #(
   parameter int DEPTH = STACK_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  turtle_type               wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output turtle_type               rd_data_ff
);

   turtle_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read returns the old contents on a same-cycle write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/tsi_sine_rom.sv =====
module tsi_sine_rom import tsi_pkg::*; #(
   parameter int TABLE_BITS = SINE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [ANGLE_W-1:0]       heading,
   output logic signed [TRIG_W-1:0] sin_ff,
   output logic signed [TRIG_W-1:0] cos_ff
);

   localparam int  N        = 1 << TABLE_BITS;
   localparam int  IW       = TABLE_BITS + 1;
   localparam real STEP_RAD = PI_VALUE / (2.0 * N);

   typedef logic [TRIG_W-2:0] rom_type [0:N];

   function automatic rom_type rom_fill();
      rom_type t;
      real     a;
      for (int i = 0; i <= N; i++) begin
         a = 16384.0 * $sin(STEP_RAD * i);
         t[i] = (TRIG_W-1)'($rtoi(a + 0.5));
      end
      return t;
   endfunction

   localparam rom_type SINE_ROM = rom_fill();

   logic [1:0]            quad_sin;
   logic [1:0]            quad_cos;
   logic [TABLE_BITS-1:0] k;
   logic [IW-1:0]         idx_sin;
   logic [IW-1:0]         idx_cos;
   logic [TRIG_W-1:0]     mag_sin;
   logic [TRIG_W-1:0]     mag_cos;

   always_comb begin
      quad_sin = heading[ANGLE_W-1 -: 2];
      quad_cos = quad_sin + 2'd1;   // cosine is sine a quarter turn on
      k        = heading[ANGLE_W-3 -: TABLE_BITS];
      // odd quadrants walk the quarter wave backwards
      idx_sin  = quad_sin[0] ? (IW'(N) - {1'b0, k}) : {1'b0, k};
      idx_cos  = quad_cos[0] ? (IW'(N) - {1'b0, k}) : {1'b0, k};
      mag_sin  = {1'b0, SINE_ROM[idx_sin]};
      mag_cos  = {1'b0, SINE_ROM[idx_cos]};
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         sin_ff <= quad_sin[1] ? -$signed(mag_sin) : $signed(mag_sin);
         cos_ff <= quad_cos[1] ? -$signed(mag_cos) : $signed(mag_cos);
      end
   end

endmodule

// ===== rtl/turtle_symbol_interpreter.sv =====
// Each accepted symbol passes the input stage, the heading stage and the output register in turn.
// Throughput: one symbol per cycle while nothing stalls. A ']' is held while a '[' is in one of the two
// stages ahead of the stack write, and stays held while the output stalls that '['.
// A waiting result beat stalls the pipeline only once the next result reaches it.
// Reset (synchronous) empties the pipeline, loads the default registers and
// start pose and empties the stack; stack memory contents are not cleared.
module turtle_symbol_interpreter import tsi_pkg::*; #(
   parameter int STACK_DEPTH     = STACK_DEPTH_DEF,
   parameter int SINE_TABLE_BITS = SINE_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   tsi_req_if.sink   req_bus,
   tsi_rsp_if.source rsp_bus,
   tsi_csr_if.sink   csr_bus
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int LW = $clog2(STACK_DEPTH + 1);

   typedef struct packed {
      op_type        op;
      logic          ws;
      logic [AW-1:0] addr;
   } s1_type;

   typedef struct packed {
      op_type             op;
      logic               ws;
      logic [AW-1:0]      addr;
      logic [ANGLE_W-1:0] h;
      logic [COORD_W-1:0] pop_x;
      logic [COORD_W-1:0] pop_y;
   } s2_type;

   // configuration
   logic [ANGLE_W-1:0] turn_step_ff;
   logic [STEP_W-1:0]  step_length_ff;
   logic [COORD_W-1:0] start_x_ff;
   logic [COORD_W-1:0] start_y_ff;
   logic [ANGLE_W-1:0] start_heading_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_step_ff     <= TURN_STEP_RESET;
         step_length_ff   <= STEP_LENGTH_RESET;
         start_x_ff       <= START_X_RESET;
         start_y_ff       <= START_Y_RESET;
         start_heading_ff <= START_HEADING_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_TURN_STEP:     turn_step_ff     <= csr_bus.data[ANGLE_W-1:0];
            CSR_STEP_LENGTH:   step_length_ff   <= csr_bus.data[STEP_W-1:0];
            CSR_START_X:       start_x_ff       <= csr_bus.data[COORD_W-1:0];
            CSR_START_Y:       start_y_ff       <= csr_bus.data[COORD_W-1:0];
            CSR_START_HEADING: start_heading_ff <= csr_bus.data[ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic   s1_valid_ff, s1_valid_in;
   s1_type s1_ff, s1_in;
   logic   s2_valid_ff, s2_valid_in;
   s2_type s2_ff, s2_in;
   logic   rsp_valid_ff;
   logic   out_free;
   logic   s2_result;
   logic   fire1, fire2;
   logic   accept;
   logic   push_inflight;

   // input stage: decode, stack level, stack read
   logic [LW-1:0] level_ff, level_in;
   logic [LW-1:0] lvl_base;
   logic [LW-1:0] lvl_dec;
   op_type        op_in;

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   turtle_type    mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   turtle_type    mem_rd_data;

   always_comb begin
      lvl_base = req_bus.word_start ? '0 : level_ff;
      lvl_dec  = lvl_base - LW'(1);
      op_in    = OP_IDLE;
      unique case (req_bus.symbol)
         SYM_FORWARD: op_in = OP_FORWARD;
         SYM_PUSH:    op_in = (lvl_base == LW'(STACK_DEPTH)) ? OP_OVERFLOW : OP_PUSH;
         SYM_POP:     op_in = (lvl_base == '0) ? OP_UNDERFLOW : OP_POP;
         SYM_LEFT:    op_in = OP_LEFT;
         SYM_RIGHT:   op_in = OP_RIGHT;
         default:     op_in = OP_IDLE;
      endcase
      case (op_in)
         OP_PUSH: level_in = lvl_base + LW'(1);
         OP_POP:  level_in = lvl_dec;
         default: level_in = lvl_base;
      endcase
      s1_in.op   = op_in;
      s1_in.ws   = req_bus.word_start;
      s1_in.addr = (op_in == OP_POP) ? lvl_dec[AW-1:0] : lvl_base[AW-1:0];
   end

   assign push_inflight = (s1_valid_ff && s1_ff.op == OP_PUSH) ||
                          (s2_valid_ff && s2_ff.op == OP_PUSH);

   // hold a pop until every older push has reached the stack memory
   assign req_bus.ready = (!s1_valid_ff || fire1) && !(op_in == OP_POP && push_inflight);
   assign accept        = req_bus.valid && req_bus.ready;
   assign mem_rd_en     = accept && op_in == OP_POP;
   assign mem_rd_addr   = s1_in.addr;

   assign fire1       = s1_valid_ff && (!s2_valid_ff || fire2);
   assign s1_valid_in = accept ? 1'b1 : (fire1 ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         level_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            level_ff <= level_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   tsi_stack_mem #(
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_data   (mem_wr_data),
      .rd_en     (mem_rd_en),
      .rd_addr   (mem_rd_addr),
      .rd_data_ff(mem_rd_data)
   );

   // heading stage
   logic [ANGLE_W-1:0] heading_ff, heading_in;
   logic [ANGLE_W-1:0] base_h;

   always_comb begin
      base_h = s1_ff.ws ? start_heading_ff : heading_ff;
      case (s1_ff.op)
         OP_LEFT:  heading_in = base_h + turn_step_ff;
         OP_RIGHT: heading_in = base_h - turn_step_ff;
         OP_POP:   heading_in = mem_rd_data.h;
         default:  heading_in = base_h;
      endcase
      s2_in.op    = s1_ff.op;
      s2_in.ws    = s1_ff.ws;
      s2_in.addr  = s1_ff.addr;
      s2_in.h     = base_h;
      s2_in.pop_x = mem_rd_data.x;
      s2_in.pop_y = mem_rd_data.y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_ff <= START_HEADING_RESET;
      end else if (fire1) begin
         heading_ff <= heading_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire1) begin
         s2_ff <= s2_in;
      end
   end

   logic signed [TRIG_W-1:0] sin_val;
   logic signed [TRIG_W-1:0] cos_val;

   tsi_sine_rom #(
      .TABLE_BITS(SINE_TABLE_BITS)
   ) u_sine (
      .clock  (clock),
      .rd_en  (fire1),
      .heading(base_h),
      .sin_ff (sin_val),
      .cos_ff (cos_val)
   );

   // position stage
   logic [COORD_W-1:0] pos_x_ff, pos_x_in;
   logic [COORD_W-1:0] pos_y_ff, pos_y_in;
   logic [COORD_W-1:0] base_x, base_y;
   logic [COORD_W-1:0] new_x, new_y;
   logic signed [STEP_W+TRIG_W:0] prod_x, prod_y;
   logic signed [STEP_W+TRIG_W:0] rnd_x, rnd_y;

   always_comb begin
      base_x = s2_ff.ws ? start_x_ff : pos_x_ff;
      base_y = s2_ff.ws ? start_y_ff : pos_y_ff;
      prod_x = $signed({1'b0, step_length_ff}) * cos_val;
      prod_y = $signed({1'b0, step_length_ff}) * sin_val;
      // round half up, then floor shift back to Q15.8
      rnd_x  = prod_x + (STEP_W+TRIG_W+1)'(8192);
      rnd_y  = prod_y + (STEP_W+TRIG_W+1)'(8192);
      new_x  = base_x + COORD_W'($signed(rnd_x[STEP_W+TRIG_W:14]));
      new_y  = base_y + COORD_W'($signed(rnd_y[STEP_W+TRIG_W:14]));
      case (s2_ff.op)
         OP_FORWARD: begin
            pos_x_in = new_x;
            pos_y_in = new_y;
         end
         OP_POP: begin
            pos_x_in = s2_ff.pop_x;
            pos_y_in = s2_ff.pop_y;
         end
         default: begin
            pos_x_in = base_x;
            pos_y_in = base_y;
         end
      endcase
   end

   assign s2_result = s2_ff.op == OP_FORWARD || s2_ff.op == OP_OVERFLOW ||
                      s2_ff.op == OP_UNDERFLOW;
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign fire2     = s2_valid_ff && (out_free || !s2_result);
   assign s2_valid_in = fire1 ? 1'b1 : (fire2 ? 1'b0 : s2_valid_ff);

   assign mem_wr_en   = fire2 && s2_ff.op == OP_PUSH;
   assign mem_wr_addr = s2_ff.addr;
   assign mem_wr_data = '{x: base_x, y: base_y, h: s2_ff.h};

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         pos_x_ff    <= START_X_RESET;
         pos_y_ff    <= START_Y_RESET;
      end else begin
         s2_valid_ff <= s2_valid_in;
         if (fire2) begin
            pos_x_ff <= pos_x_in;
            pos_y_ff <= pos_y_in;
         end
      end
   end

   // output register
   logic [COORD_W-1:0] seg_x0_ff, seg_y0_ff, seg_x1_ff, seg_y1_ff;
   status_type         status_ff;
   status_type         status_in;

   always_comb begin
      case (s2_ff.op)
         OP_OVERFLOW:  status_in = STATUS_OVERFLOW;
         OP_UNDERFLOW: status_in = STATUS_UNDERFLOW;
         default:      status_in = STATUS_SEGMENT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire2 && s2_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire2 && s2_result) begin
         seg_x0_ff <= base_x;
         seg_y0_ff <= base_y;
         seg_x1_ff <= pos_x_in;
         seg_y1_ff <= pos_y_in;
         status_ff <= status_in;
      end
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.seg_x0 = seg_x0_ff;
   assign rsp_bus.seg_y0 = seg_y0_ff;
   assign rsp_bus.seg_x1 = seg_x1_ff;
   assign rsp_bus.seg_y1 = seg_y1_ff;
   assign rsp_bus.status = status_ff;

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LW'(STACK_DEPTH))
      else $error("stack level beyond depth");

   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
      else $error("pop read races a push to the same entry");

   a_result_slot: assert property (@(posedge clock) disable iff (reset)
      (fire2 && s2_result) |-> out_free)
      else $error("result loaded over an untaken beat");

   a_pop_sees_push: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |=> !(s1_valid_ff && s1_ff.op == OP_POP && $past(mem_rd_en)
                      && $past(mem_wr_addr) == s1_ff.addr))
      else $error("pop took stale stack data");

endmodule
